/* rtl/rcfsp_pkg.sv */
// ----------------------------------------------------------------------------
// rcfsp_pkg
// Shared types and constants of the RC frame setpoint parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfsp_pkg;

   // frame position counter
   localparam int unsigned POS_W = 4;

   // frame bytes
   localparam logic [7:0] START_BYTE = 8'h24;   // '$'
   localparam logic [7:0] FRAME_ID   = 8'd150;

   // captured bytes: positions FIRST_CAPTURE .. FIRST_CAPTURE+CAPTURE_COUNT-1
   localparam logic [POS_W-1:0] FIRST_CAPTURE = 4'd4;
   localparam int unsigned      CAPTURE_COUNT = 5;
   localparam int unsigned      CAP_ID        = 0;
   localparam int unsigned      CAP_ROLL      = 1;
   localparam int unsigned      CAP_PITCH     = 2;
   localparam int unsigned      CAP_YAW       = 3;
   localparam int unsigned      CAP_THROTTLE  = 4;

   // setpoint math
   localparam logic signed [11:0] STICK_CENTER   = 12'sd125;
   localparam logic signed [17:0] SETPOINT_LIMIT = 18'sd19040;

   // register indexes
   localparam int unsigned      CSR_IDX_W      = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ROLL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PITCH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_YAW   = 2'd2;

   // completed frame, stick bytes as captured
   typedef struct packed {
      logic       emit;
      logic [7:0] throttle;
      logic [7:0] roll_stick;
      logic [7:0] pitch_stick;
      logic [7:0] yaw_stick;
   } frame_event_type;

   // one result item
   typedef struct packed {
      logic [7:0]         throttle_cmd;
      logic signed [15:0] roll_setpoint;
      logic signed [15:0] pitch_setpoint;
      logic signed [15:0] yaw_setpoint;
   } result_type;

endpackage

`default_nettype wire

/* rtl/rcfsp_frame_tracker.sv */
// ----------------------------------------------------------------------------
// rcfsp_frame_tracker
// Frame position counter and capture registers; flags a complete frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfsp_frame_tracker
   import rcfsp_pkg::*;
#(
   parameter int LAST_POS = 10
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            byte_accept,
   input  wire logic [7:0]      rx_byte,
   output frame_event_type      frame_event
);

   localparam logic [POS_W-1:0] LastPosC = POS_W'(LAST_POS);

   logic [POS_W-1:0] pos_ff, pos_in, pos_inc;
   logic [7:0]       cap_ff [CAPTURE_COUNT];
   logic [7:0]       cap_in [CAPTURE_COUNT];
   logic             advance;

   assign pos_inc = pos_ff + 1'b1;
   assign advance = byte_accept && (rx_byte != START_BYTE) && (pos_ff <= LastPosC);

   always_comb begin
      pos_in = pos_ff;
      for (int i = 0; i < CAPTURE_COUNT; i++) begin
         cap_in[i] = cap_ff[i];
      end
      if (byte_accept && (rx_byte == START_BYTE)) begin
         pos_in = '0;
      end else if (advance) begin
         pos_in = pos_inc;
         for (int i = 0; i < CAPTURE_COUNT; i++) begin
            if (pos_inc == FIRST_CAPTURE + POS_W'(i)) begin
               cap_in[i] = rx_byte;
            end
         end
      end
   end

   // next capture values feed the event so a short frame sees its last byte
   always_comb begin
      frame_event.emit        = advance && (pos_inc == LastPosC)
                                && (cap_in[CAP_ID] == FRAME_ID);
      frame_event.throttle    = cap_in[CAP_THROTTLE];
      frame_event.roll_stick  = cap_in[CAP_ROLL];
      frame_event.pitch_stick = cap_in[CAP_PITCH];
      frame_event.yaw_stick   = cap_in[CAP_YAW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPTURE_COUNT; i++) begin
         cap_ff[i] <= cap_in[i];
      end
   end

endmodule

`default_nettype wire

/* rtl/rcfsp_setpoint_calc.sv */
// ----------------------------------------------------------------------------
// rcfsp_setpoint_calc
// Stick bytes to saturated attitude setpoints in centidegrees.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfsp_setpoint_calc
   import rcfsp_pkg::*;
(
   input  wire frame_event_type     frame_event,
   input  wire logic signed [15:0]  base_roll,
   input  wire logic signed [15:0]  base_pitch,
   input  wire logic signed [15:0]  base_yaw,
   output result_type               result
);

   // base +/- (stick - 125) * 8, clamped to +/-19040
   function automatic logic signed [15:0] calc_setpoint(
      input logic signed [15:0] base,
      input logic [7:0]         stick,
      input logic               negate
   );
      logic signed [11:0] diff;
      logic signed [11:0] delta;
      logic signed [17:0] base_x;
      logic signed [17:0] delta_x;
      logic signed [17:0] sum;
      logic signed [15:0] sp;
      diff    = $signed({4'b0000, stick}) - STICK_CENTER;
      delta   = {diff[8:0], 3'b000};
      base_x  = {{2{base[15]}}, base};
      delta_x = {{6{delta[11]}}, delta};
      sum     = negate ? (base_x - delta_x) : (base_x + delta_x);
      if (sum > SETPOINT_LIMIT) begin
         sp = SETPOINT_LIMIT[15:0];
      end else if (sum < -SETPOINT_LIMIT) begin
         sp = 16'(-SETPOINT_LIMIT);
      end else begin
         sp = sum[15:0];
      end
      return sp;
   endfunction

   always_comb begin
      result.throttle_cmd   = frame_event.throttle;
      result.roll_setpoint  = calc_setpoint(base_roll,  frame_event.roll_stick,  1'b1);
      result.pitch_setpoint = calc_setpoint(base_pitch, frame_event.pitch_stick, 1'b0);
      result.yaw_setpoint   = calc_setpoint(base_yaw,   frame_event.yaw_stick,   1'b1);
   end

endmodule

`default_nettype wire

/* rtl/rcfsp_out_buffer.sv */
// ----------------------------------------------------------------------------
// rcfsp_out_buffer
// Result register plus skid entry between the parser and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfsp_out_buffer
   import rcfsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire result_type  in_result,
   output logic             full,
   output logic             out_valid,
   output result_type       out_result,
   input  wire logic        out_stall
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_free;

   // out register can load when empty or drained this cycle
   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_in       = in_result;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full       = skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

`default_nettype wire

/* rtl/rc_frame_setpoint_parser_core.sv */
// ----------------------------------------------------------------------------
// rc_frame_setpoint_parser_core
// RC frame parser: serial bytes in, throttle and attitude setpoints out.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one received byte per transfer (req_valid/req_stall).
//    A '$' byte restarts the frame; the next bytes step the frame position,
//    positions 4..8 are captured, and at position LAST_POS a frame whose
//    position-4 byte is 150 yields one rsp_ transfer. Bytes past LAST_POS
//    are dropped until the next '$'.
//  - rsp_ channel: throttle plus roll/pitch/yaw setpoints in centidegrees,
//    each = base -/+ (stick - 125) * 8, clamped to +/-19040.
//  - csr_ port: write base_roll (0), base_pitch (1), base_yaw (2) only while
//    idle; other indexes are ignored.
//  - The closing byte's result loads the result register, or the skid
//    entry while that register is stalled. Throughput: one byte per cycle
//    while req_stall is low; all parsing and setpoint math is combinational.
//  - Stall: a stalled result is held; a second result parks in a skid entry
//    and req_stall rises only while that entry is occupied.
//  - Reset: frame position, valid flags and base registers clear to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_frame_setpoint_parser_core
   import rcfsp_pkg::*;
#(
   parameter int LAST_POS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata,
   // byte input
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_rx_byte,
   // results
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_throttle_cmd,
   output logic signed [15:0]        rsp_roll_setpoint,
   output logic signed [15:0]        rsp_pitch_setpoint,
   output logic signed [15:0]        rsp_yaw_setpoint
);

   logic signed [15:0] base_roll_ff, base_pitch_ff, base_yaw_ff;
   logic signed [15:0] base_roll_in, base_pitch_in, base_yaw_in;
   logic               byte_accept;
   logic               buf_full;
   frame_event_type    frame_event;
   result_type         calc_result;
   result_type         rsp_result;

   // ---- calibration registers ----
   always_comb begin
      base_roll_in  = base_roll_ff;
      base_pitch_in = base_pitch_ff;
      base_yaw_in   = base_yaw_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_ROLL:  base_roll_in  = csr_wdata;
            CSR_BASE_PITCH: base_pitch_in = csr_wdata;
            CSR_BASE_YAW:   base_yaw_in   = csr_wdata;
            default: ;      // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_roll_ff  <= '0;
         base_pitch_ff <= '0;
         base_yaw_ff   <= '0;
      end else begin
         base_roll_ff  <= base_roll_in;
         base_pitch_ff <= base_pitch_in;
         base_yaw_ff   <= base_yaw_in;
      end
   end

   // ---- input handshake ----
   // stall only while the skid entry holds a result
   assign req_stall   = buf_full;
   assign byte_accept = req_valid && !req_stall;

   // ---- frame tracking ----
   rcfsp_frame_tracker #(
      .LAST_POS (LAST_POS)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .frame_event (frame_event)
   );

   // ---- setpoint math ----
   rcfsp_setpoint_calc u_calc (
      .frame_event (frame_event),
      .base_roll   (base_roll_ff),
      .base_pitch  (base_pitch_ff),
      .base_yaw    (base_yaw_ff),
      .result      (calc_result)
   );

   // ---- result register and skid ----
   rcfsp_out_buffer u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (frame_event.emit),
      .in_result  (calc_result),
      .full       (buf_full),
      .out_valid  (rsp_valid),
      .out_result (rsp_result),
      .out_stall  (rsp_stall)
   );

   assign rsp_throttle_cmd   = rsp_result.throttle_cmd;
   assign rsp_roll_setpoint  = rsp_result.roll_setpoint;
   assign rsp_pitch_setpoint = rsp_result.pitch_setpoint;
   assign rsp_yaw_setpoint   = rsp_result.yaw_setpoint;

endmodule

`default_nettype wire
